// File: hw/rtl/asca_pkg.sv
// ----------------------------------------------------------------------------
// asca_pkg
// Types and constants shared by the nine-point stencil entry generator.
// ----------------------------------------------------------------------------
package asca_pkg;

	localparam int NUM_ENTRIES = 9;
	localparam logic [3:0] ENTRY_LAST = 4'd8;

	localparam logic [10:0] GRID_WIDTH_RESET  = 11'd1024;
	localparam logic [10:0] GRID_HEIGHT_RESET = 11'd1024;
	localparam logic [31:0] RATIO_RESET       = 32'd65536;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1,
		REG_RATIO_Y_X   = 2'd2,
		REG_RATIO_X_Y   = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic        [9:0]  cell_x;
		logic        [9:0]  cell_y;
		logic signed [31:0] face0_xx;
		logic signed [31:0] face1_xx;
		logic signed [31:0] face2_yy;
		logic signed [31:0] face3_yy;
		logic signed [31:0] face2_xy;
		logic signed [31:0] face3_xy;
		logic signed [31:0] face0_yx;
		logic signed [31:0] face1_yx;
	} item_t;

	typedef struct packed {
		logic        [19:0] row_index;
		logic        [19:0] col_index;
		logic signed [47:0] entry_value;
		logic               last_entry;
	} result_t;

	typedef struct packed {
		logic [10:0] grid_width;
		logic [10:0] grid_height;
		logic [31:0] ratio_y_over_x;
		logic [31:0] ratio_x_over_y;
	} cfg_t;

	// the nine entries of one cell, in emission order
	typedef struct packed {
		logic [19:0]       row;
		logic [8:0][19:0]  col;
		logic [8:0][47:0]  val;
	} entries_t;

	typedef struct packed {
		logic     valid;
		entries_t entries;
	} cell_t;

endpackage

// File: hw/rtl/asca_pipe.sv
// ----------------------------------------------------------------------------
// asca_pipe
// Four-stage datapath: input capture, ratio products and neighbor indexes,
// rounding and stencil sums, saturation, edge masking and column indexes.
// ----------------------------------------------------------------------------
module asca_pipe #(
	parameter int MAX_GRID_WIDTH  = 1024,
	parameter int MAX_GRID_HEIGHT = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  asca_pkg::item_t  in_item,
	output logic             in_ready,
	input  asca_pkg::cfg_t   cfg,
	input  logic             out_free,
	output asca_pkg::cell_t  out_cell
);

	localparam logic [31:0] MAX_W32 = 32'(MAX_GRID_WIDTH);
	localparam logic [31:0] MAX_H32 = 32'(MAX_GRID_HEIGHT);
	localparam logic [10:0] MAX_W11 = MAX_W32[10:0];
	localparam logic [10:0] MAX_H11 = MAX_H32[10:0];

	// (d + 2) >> 2 with floor
	function automatic logic signed [31:0] quarter(input logic signed [32:0] d);
		logic signed [33:0] t;
		t = $signed({d[32], d}) + 34'sd2;
		return t[33:2];
	endfunction

	// (p + 2^15) >> 16 with floor
	function automatic logic signed [48:0] round16(input logic signed [64:0] p);
		logic signed [64:0] t;
		t = p + 65'sd32768;
		return t[64:16];
	endfunction

	function automatic logic [47:0] sat48(input logic signed [51:0] v);
		logic [47:0] r;
		if (v[51:47] == 5'b00000 || v[51:47] == 5'b11111) begin
			r = v[47:0];
		end else if (v[51]) begin
			r = {1'b1, 47'd0};
		end else begin
			r = {1'b0, {47{1'b1}}};
		end
		return r;
	endfunction

	// stage enables, back to front
	logic en1, en2, en3, en4, take4;

	logic             valid_s1;
	asca_pkg::item_t  item_s1;

	logic                valid_s2, in_grid_s2;
	logic [3:0]          edge_s2;
	logic signed [64:0]  prod_s2 [4];
	logic signed [31:0]  qt_s2 [6];
	logic [9:0]          x_s2, y_s2;
	logic [10:0]         xn_s2, xp_s2, yn_s2, yp_s2, w_s2;

	logic                valid_s3, in_grid_s3;
	logic [3:0]          edge_s3;
	logic signed [51:0]  v_s3 [9];
	logic [20:0]         rk_s3;
	logic [21:0]         ryp_s3, ryn_s3;
	logic [10:0]         x_s3, xn_s3, xp_s3;

	logic                valid_s4, in_grid_s4;
	asca_pkg::entries_t  entries_s4;

	assign take4    = valid_s4 && (!in_grid_s4 || out_free);
	assign en4      = !valid_s4 || take4;
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	// stage 1: capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// stage 2 logic
	logic [10:0] w, h, x11, y11;
	logic        el, er, eb, et, in_grid;
	logic [10:0] xn, xp, yn, yp;
	logic signed [64:0] prod [4];
	logic signed [31:0] qt [6];

	always_comb begin
		if (cfg.grid_width == 11'd0) begin
			w = 11'd1;
		end else if ({21'd0, cfg.grid_width} > MAX_W32) begin
			w = MAX_W11;
		end else begin
			w = cfg.grid_width;
		end
		if (cfg.grid_height == 11'd0) begin
			h = 11'd1;
		end else if ({21'd0, cfg.grid_height} > MAX_H32) begin
			h = MAX_H11;
		end else begin
			h = cfg.grid_height;
		end
		x11     = {1'b0, item_s1.cell_x};
		y11     = {1'b0, item_s1.cell_y};
		in_grid = (x11 < w) && (y11 < h);
		el      = (x11 == 11'd0);
		er      = (x11 == w - 11'd1);
		eb      = (y11 == 11'd0);
		et      = (y11 == h - 11'd1);
		xn      = el ? w - 11'd1 : x11 - 11'd1;
		xp      = er ? 11'd0 : x11 + 11'd1;
		yn      = eb ? h - 11'd1 : y11 - 11'd1;
		yp      = et ? 11'd0 : y11 + 11'd1;

		prod[0] = $signed({1'b0, cfg.ratio_y_over_x}) * item_s1.face0_xx;
		prod[1] = $signed({1'b0, cfg.ratio_y_over_x}) * item_s1.face1_xx;
		prod[2] = $signed({1'b0, cfg.ratio_x_over_y}) * item_s1.face2_yy;
		prod[3] = $signed({1'b0, cfg.ratio_x_over_y}) * item_s1.face3_yy;

		// g-e, q-p, g+q, e+p, g+p, e+q
		qt[0] = quarter(33'(item_s1.face3_xy) - 33'(item_s1.face2_xy));
		qt[1] = quarter(33'(item_s1.face1_yx) - 33'(item_s1.face0_yx));
		qt[2] = quarter(33'(item_s1.face3_xy) + 33'(item_s1.face1_yx));
		qt[3] = quarter(33'(item_s1.face2_xy) + 33'(item_s1.face0_yx));
		qt[4] = quarter(33'(item_s1.face3_xy) + 33'(item_s1.face0_yx));
		qt[5] = quarter(33'(item_s1.face2_xy) + 33'(item_s1.face1_yx));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			in_grid_s2 <= in_grid;
			edge_s2    <= {et, eb, er, el};
			prod_s2    <= prod;
			qt_s2      <= qt;
			x_s2       <= item_s1.cell_x;
			y_s2       <= item_s1.cell_y;
			xn_s2      <= xn;
			xp_s2      <= xp;
			yn_s2      <= yn;
			yp_s2      <= yp;
			w_s2       <= w;
		end
	end

	// stage 3 logic
	logic signed [51:0] m [4];
	logic signed [51:0] ex, ey;
	logic signed [51:0] v [9];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			m[i] = 52'(round16(prod_s2[i]));
		end
		ex   = 52'(qt_s2[0]);
		ey   = 52'(qt_s2[1]);
		v[0] = -(m[1] + m[0]) - (m[3] + m[2]);
		v[1] = m[1] + ex;
		v[2] = m[0] - ex;
		v[3] = m[3] + ey;
		v[4] = m[2] - ey;
		v[5] = 52'(qt_s2[2]);
		v[6] = 52'(qt_s2[3]);
		v[7] = -52'(qt_s2[4]);
		v[8] = -52'(qt_s2[5]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			in_grid_s3 <= in_grid_s2;
			edge_s3    <= edge_s2;
			v_s3       <= v;
			rk_s3      <= 21'(y_s2) * 21'(w_s2);
			ryp_s3     <= 22'(yp_s2) * 22'(w_s2);
			ryn_s3     <= 22'(yn_s2) * 22'(w_s2);
			x_s3       <= {1'b0, x_s2};
			xn_s3      <= xn_s2;
			xp_s3      <= xp_s2;
		end
	end

	// stage 4 logic
	logic [8:0]          zero;
	asca_pkg::entries_t  ent;
	logic [22:0]         rk, ryp, ryn;

	always_comb begin
		// edge_s3 bits: left, right, bottom, top
		zero = 9'd0;
		if (edge_s3[0]) begin
			zero[2] = 1'b1; zero[6] = 1'b1; zero[7] = 1'b1;
		end
		if (edge_s3[1]) begin
			zero[1] = 1'b1; zero[5] = 1'b1; zero[8] = 1'b1;
		end
		if (edge_s3[2]) begin
			zero[4] = 1'b1; zero[6] = 1'b1; zero[8] = 1'b1;
		end
		if (edge_s3[3]) begin
			zero[3] = 1'b1; zero[5] = 1'b1; zero[7] = 1'b1;
		end
		for (int i = 0; i < asca_pkg::NUM_ENTRIES; i++) begin
			ent.val[i] = zero[i] ? 48'd0 : sat48(v_s3[i]);
		end
		rk  = {2'b00, rk_s3};
		ryp = {1'b0, ryp_s3};
		ryn = {1'b0, ryn_s3};
		ent.col[0] = 20'(rk  + 23'(x_s3));
		ent.col[1] = 20'(rk  + 23'(xp_s3));
		ent.col[2] = 20'(rk  + 23'(xn_s3));
		ent.col[3] = 20'(ryp + 23'(x_s3));
		ent.col[4] = 20'(ryn + 23'(x_s3));
		ent.col[5] = 20'(ryp + 23'(xp_s3));
		ent.col[6] = 20'(ryn + 23'(xn_s3));
		ent.col[7] = 20'(ryp + 23'(xn_s3));
		ent.col[8] = 20'(ryn + 23'(xp_s3));
		ent.row    = ent.col[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			in_grid_s4 <= in_grid_s3;
			entries_s4 <= ent;
		end
	end

	// cells outside the grid leave stage 4 without results
	assign out_cell.valid   = valid_s4 && in_grid_s4;
	assign out_cell.entries = entries_s4;

endmodule

// File: hw/rtl/anisotropic_stencil_coo_assembly.sv
// ----------------------------------------------------------------------------
// anisotropic_stencil_coo_assembly
// Nine-point anisotropic diffusion stencil, sparse matrix entry generator.
// ----------------------------------------------------------------------------
// A cell (position and eight face tensor coefficients) is taken on item at a
// rising edge where start is high and busy is low. Each cell inside the grid
// yields nine entries on result, one per cycle in consecutive cycles, each
// marked by strobe for exactly one cycle: centre, east, west, north, south,
// NE, SW, NW, SE; last_entry flags the ninth. Cells outside the grid are
// dropped without any result.
// A cell passes four register stages, then the entry buffer, before its first
// entry reaches the ports. The single result port drains the nine-entry
// buffer before the next cell loads; up to four further cells wait in the
// pipeline, and busy rises once they fill it.
// Configuration is written through wr_en, wr_index and wr_data, one register
// per edge; the user must write only while the block is idle, and the block
// itself does not enforce it.
// Reset returns the registers to their defaults (1024 x 1024 grid, ratios
// 1.0) and empties pipeline and buffer. The receiver cannot stall.
// ----------------------------------------------------------------------------
module anisotropic_stencil_coo_assembly #(
	parameter int MAX_GRID_WIDTH  = 1024,
	parameter int MAX_GRID_HEIGHT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  asca_pkg::item_t    item,
	output logic               strobe,
	output asca_pkg::result_t  result,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [31:0]        wr_data
);

	asca_pkg::cfg_t      cfg_q;
	asca_pkg::cell_t     pipe_cell;
	asca_pkg::entries_t  em_entries_q;
	logic                em_active_q;
	logic [3:0]          em_cnt_q;
	logic                em_last, out_free, load, ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width     <= asca_pkg::GRID_WIDTH_RESET;
			cfg_q.grid_height    <= asca_pkg::GRID_HEIGHT_RESET;
			cfg_q.ratio_y_over_x <= asca_pkg::RATIO_RESET;
			cfg_q.ratio_x_over_y <= asca_pkg::RATIO_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				asca_pkg::REG_GRID_WIDTH:  cfg_q.grid_width     <= wr_data[10:0];
				asca_pkg::REG_GRID_HEIGHT: cfg_q.grid_height    <= wr_data[10:0];
				asca_pkg::REG_RATIO_Y_X:   cfg_q.ratio_y_over_x <= wr_data;
				asca_pkg::REG_RATIO_X_Y:   cfg_q.ratio_x_over_y <= wr_data;
				default: ;
			endcase
		end
	end

	asca_pipe #(
		.MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
		.MAX_GRID_HEIGHT (MAX_GRID_HEIGHT)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.in_item  (item),
		.in_ready (ready),
		.cfg      (cfg_q),
		.out_free (out_free),
		.out_cell (pipe_cell)
	);

	assign busy = !ready;

	// entry buffer: the next cell loads on the cycle its predecessor's last
	// entry goes out, so entries of successive cells run without a gap
	assign em_last  = (em_cnt_q == asca_pkg::ENTRY_LAST);
	assign out_free = !em_active_q || em_last;
	assign load     = pipe_cell.valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_active_q <= 1'b0;
			em_cnt_q    <= 4'd0;
		end else if (load) begin
			em_active_q <= 1'b1;
			em_cnt_q    <= 4'd0;
		end else if (em_active_q) begin
			if (em_last) begin
				em_active_q <= 1'b0;
			end else begin
				em_cnt_q <= em_cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			em_entries_q <= pipe_cell.entries;
		end
	end

	assign strobe             = em_active_q;
	assign result.row_index   = em_entries_q.row;
	assign result.col_index   = em_entries_q.col[em_cnt_q];
	assign result.entry_value = em_entries_q.val[em_cnt_q];
	assign result.last_entry  = em_active_q && em_last;

endmodule

// File: hw/rtl/asca_checker.sv
// ----------------------------------------------------------------------------
// asca_checker
// Port-level checks on the entry stream of the stencil entry generator.
// ----------------------------------------------------------------------------
module asca_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               strobe,
	input asca_pkg::result_t  result
);

	// the nine entries of a cell come in consecutive cycles
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_entry |=> strobe)
		else $error("entry burst broken before the last entry");

	// all entries of one cell share its row
	a_row: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_entry |=> $stable(result.row_index))
		else $error("row index changed inside a cell");

	// every cell opens with its centre entry, on the diagonal
	a_centre: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (!$past(strobe) || $past(result.last_entry))
		|-> result.col_index == result.row_index)
		else $error("cell does not start with the centre entry");

	// a cell never ends in the cycle in which it starts
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_entry |-> $past(strobe) && !$past(result.last_entry))
		else $error("cell shorter than nine entries");

endmodule

bind anisotropic_stencil_coo_assembly asca_checker u_asca_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.strobe (strobe),
	.result (result)
);

// File: bench/stencil_entry_checker.sv
// ----------------------------------------------------------------------------
// stencil_entry_checker
// Watches the cell, entry and register ports of the stencil entry generator.
// It keeps its own copy of the registers and computes the nine entries for
// each accepted cell inside the grid. It compares every strobed entry with
// the oldest expected entry and counts the failures.
// ----------------------------------------------------------------------------
module stencil_entry_checker #(
	parameter int MAX_GRID_WIDTH  = 1024,
	parameter int MAX_GRID_HEIGHT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  asca_pkg::item_t    item,
	input  logic               strobe,
	input  asca_pkg::result_t  result,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [31:0]        wr_data,
	output int                 fail_count,
	output int                 pending
);
	import asca_pkg::*;

	// emission order of the entries of one cell
	typedef enum int {
		AT_CENTRE, AT_EAST, AT_WEST, AT_NORTH, AT_SOUTH, AT_NE, AT_SW, AT_NW, AT_SE
	} entry_pos_t;

	cfg_t    cfg;
	result_t expected_entries [$];
	int      errors = 0;

	assign fail_count = errors;

	// ratio times coefficient, rounded half up back to Q.16
	function automatic logic signed [63:0] ratio_scale(input logic [31:0] ratio,
			input logic signed [63:0] coef);
		logic signed [95:0] wide_ratio, wide_coef, prod;
		wide_ratio = {64'd0, ratio};
		wide_coef = coef;
		prod = (wide_ratio * wide_coef + 96'sd32768) >>> 16;
		return prod[63:0];
	endfunction

	function automatic logic signed [63:0] quarter_round(input logic signed [63:0] d);
		return (d + 64'sd2) >>> 2;
	endfunction

	function automatic logic [47:0] clip48(input logic signed [63:0] v);
		if (v > 64'sd140737488355327)
			return 48'h7FFF_FFFF_FFFF;
		if (v < -64'sd140737488355328)
			return 48'h8000_0000_0000;
		return v[47:0];
	endfunction

	// nine entries of one cell, queued in emission order
	function automatic void stencil_entries(input item_t cell_item);
		int unsigned        w, h, x, y, xm, xp, ym, yp, row;
		int unsigned        col [NUM_ENTRIES];
		logic signed [63:0] val [NUM_ENTRIES];
		logic signed [63:0] fa, fb, fc, fd, fe, fg, fp, fq;
		logic signed [63:0] ra, rb, sc, sd, cross_x, cross_y;
		result_t            entry;
		w = (cfg.grid_width == 0) ? 1 :
			(cfg.grid_width > MAX_GRID_WIDTH) ? MAX_GRID_WIDTH : cfg.grid_width;
		h = (cfg.grid_height == 0) ? 1 :
			(cfg.grid_height > MAX_GRID_HEIGHT) ? MAX_GRID_HEIGHT : cfg.grid_height;
		x = cell_item.cell_x;
		y = cell_item.cell_y;
		// cells off the grid are dropped
		if (x >= w || y >= h)
			return;
		fa = $signed(cell_item.face0_xx);
		fb = $signed(cell_item.face1_xx);
		fc = $signed(cell_item.face2_yy);
		fd = $signed(cell_item.face3_yy);
		fe = $signed(cell_item.face2_xy);
		fg = $signed(cell_item.face3_xy);
		fp = $signed(cell_item.face0_yx);
		fq = $signed(cell_item.face1_yx);
		ra = ratio_scale(cfg.ratio_y_over_x, fa);
		rb = ratio_scale(cfg.ratio_y_over_x, fb);
		sc = ratio_scale(cfg.ratio_x_over_y, fc);
		sd = ratio_scale(cfg.ratio_x_over_y, fd);
		cross_x = quarter_round(fg - fe);
		cross_y = quarter_round(fq - fp);
		val[AT_CENTRE] = -(rb + ra) - (sd + sc);
		val[AT_EAST]   = rb + cross_x;
		val[AT_WEST]   = ra - cross_x;
		val[AT_NORTH]  = sd + cross_y;
		val[AT_SOUTH]  = sc - cross_y;
		val[AT_NE]     = quarter_round(fg + fq);
		val[AT_SW]     = quarter_round(fe + fp);
		val[AT_NW]     = -quarter_round(fg + fp);
		val[AT_SE]     = -quarter_round(fe + fq);
		xm = (x == 0) ? w - 1 : x - 1;
		xp = (x == w - 1) ? 0 : x + 1;
		ym = (y == 0) ? h - 1 : y - 1;
		yp = (y == h - 1) ? 0 : y + 1;
		// couplings across a grid edge vanish, the columns still wrap
		if (x == 0) begin
			val[AT_WEST] = 0; val[AT_SW] = 0; val[AT_NW] = 0;
		end
		if (x == w - 1) begin
			val[AT_EAST] = 0; val[AT_NE] = 0; val[AT_SE] = 0;
		end
		if (y == 0) begin
			val[AT_SOUTH] = 0; val[AT_SW] = 0; val[AT_SE] = 0;
		end
		if (y == h - 1) begin
			val[AT_NORTH] = 0; val[AT_NE] = 0; val[AT_NW] = 0;
		end
		row = y * w + x;
		col[AT_CENTRE] = row;
		col[AT_EAST]   = y * w + xp;
		col[AT_WEST]   = y * w + xm;
		col[AT_NORTH]  = yp * w + x;
		col[AT_SOUTH]  = ym * w + x;
		col[AT_NE]     = yp * w + xp;
		col[AT_SW]     = ym * w + xm;
		col[AT_NW]     = yp * w + xm;
		col[AT_SE]     = ym * w + xp;
		for (int n = 0; n < NUM_ENTRIES; n++) begin
			entry.row_index   = row[19:0];
			entry.col_index   = col[n][19:0];
			entry.entry_value = clip48(val[n]);
			entry.last_entry  = (n == NUM_ENTRIES - 1);
			expected_entries.push_back(entry);
		end
	endfunction

	task automatic report_field(input string field, input longint want, input longint got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			cfg.grid_width = GRID_WIDTH_RESET;
			cfg.grid_height = GRID_HEIGHT_RESET;
			cfg.ratio_y_over_x = RATIO_RESET;
			cfg.ratio_x_over_y = RATIO_RESET;
			expected_entries.delete();
			pending <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
				REG_GRID_WIDTH:  cfg.grid_width = wr_data[10:0];
				REG_GRID_HEIGHT: cfg.grid_height = wr_data[10:0];
				REG_RATIO_Y_X:   cfg.ratio_y_over_x = wr_data;
				REG_RATIO_X_Y:   cfg.ratio_x_over_y = wr_data;
				default: ;
				endcase
			end
			if (strobe) begin
				if (expected_entries.size() == 0) begin
					$display({"%0t: unexpected entry, expected none, ",
						"actual row %0d col %0d value %0d last %0b"},
						$time, result.row_index, result.col_index,
						$signed(result.entry_value), result.last_entry);
					errors++;
				end else begin
					want = expected_entries.pop_front();
					if (want.row_index !== result.row_index)
						report_field("row_index", want.row_index, result.row_index);
					if (want.col_index !== result.col_index)
						report_field("col_index", want.col_index, result.col_index);
					if (want.entry_value !== result.entry_value)
						report_field("entry_value", $signed(want.entry_value),
							$signed(result.entry_value));
					if (want.last_entry !== result.last_entry)
						report_field("last_entry", want.last_entry, result.last_entry);
				end
			end
			if (start && !busy)
				stencil_entries(item);
			pending <= expected_entries.size();
		end
	end

endmodule

// File: bench/tb_anisotropic_stencil_coo_assembly.sv
// ----------------------------------------------------------------------------
// tb_anisotropic_stencil_coo_assembly
// Drives cells and register writes into the stencil entry generator. A short
// directed part covers the grid corners, single-cell grids, cells off the grid
// and saturating coefficients. Random phases follow with new grid sizes and
// ratios and with different sender idle rates. The checker instance predicts
// and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_anisotropic_stencil_coo_assembly;
	import asca_pkg::*;

	localparam int MAX_GRID_WIDTH  = 1024;
	localparam int MAX_GRID_HEIGHT = 1024;
	localparam int LIMIT_CYCLES    = 200000;
	localparam int SETTLE_CYCLES   = 64;
	localparam int PHASES          = 5;
	localparam int CELLS_PER_PHASE = 82;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	item_t       item = '0;
	logic        strobe;
	result_t     result;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = '0;
	logic [31:0] wr_data = '0;
	int          fail_count;
	int          pending;
	int          cycles = 0;
	int          grid_w = MAX_GRID_WIDTH;
	int          grid_h = MAX_GRID_HEIGHT;

	anisotropic_stencil_coo_assembly #(
		.MAX_GRID_WIDTH (MAX_GRID_WIDTH),
		.MAX_GRID_HEIGHT(MAX_GRID_HEIGHT)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.strobe  (strobe),
		.result  (result),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data)
	);

	stencil_entry_checker #(
		.MAX_GRID_WIDTH (MAX_GRID_WIDTH),
		.MAX_GRID_HEIGHT(MAX_GRID_HEIGHT)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.strobe    (strobe),
		.result    (result),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// all four registers, one per edge; upper bits of the size writes are noise
	task automatic write_config(input logic [10:0] w, input logic [10:0] h,
			input logic [31:0] ryx, input logic [31:0] rxy);
		logic [31:0] junk;
		junk = $urandom();
		wr_en <= 1'b1;
		wr_index <= REG_GRID_WIDTH;
		wr_data <= {junk[31:11], w};
		@(posedge clk);
		junk = $urandom();
		wr_index <= REG_GRID_HEIGHT;
		wr_data <= {junk[31:11], h};
		@(posedge clk);
		wr_index <= REG_RATIO_Y_X;
		wr_data <= ryx;
		@(posedge clk);
		wr_index <= REG_RATIO_X_Y;
		wr_data <= rxy;
		@(posedge clk);
		wr_en <= 1'b0;
		grid_w = (w == 0) ? 1 : (w > MAX_GRID_WIDTH) ? MAX_GRID_WIDTH : w;
		grid_h = (h == 0) ? 1 : (h > MAX_GRID_HEIGHT) ? MAX_GRID_HEIGHT : h;
	endtask

	// hold off until every expected entry is out, then let dropped cells drain
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_cell(input item_t cell_item, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= cell_item;
		do @(posedge clk); while (busy);
	endtask

	function automatic item_t make_cell(input int x, input int y, input logic [255:0] faces);
		return {x[9:0], y[9:0], faces};
	endfunction

	function automatic logic [255:0] random_faces();
		return {$urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom()};
	endfunction

	function automatic logic [31:0] random_face();
		case ($urandom_range(7))
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return 32'($urandom_range(262143)) - 32'd131072;
		3: return 32'h0;
		default: return $urandom();
		endcase
	endfunction

	// edges favored; now and then a coordinate off the grid
	function automatic logic [9:0] random_coord(input int span);
		int pick;
		pick = $urandom_range(19);
		if (span < 1024 && pick == 0)
			return 10'($urandom_range(1023, span));
		if (pick == 1)
			return 10'd0;
		if (pick == 2)
			return 10'(span - 1);
		return 10'($urandom_range(span - 1, 0));
	endfunction

	function automatic item_t random_cell();
		item_t cell_item;
		cell_item.cell_x   = random_coord(grid_w);
		cell_item.cell_y   = random_coord(grid_h);
		cell_item.face0_xx = random_face();
		cell_item.face1_xx = random_face();
		cell_item.face2_yy = random_face();
		cell_item.face3_yy = random_face();
		cell_item.face2_xy = random_face();
		cell_item.face3_xy = random_face();
		cell_item.face0_yx = random_face();
		cell_item.face1_yx = random_face();
		return cell_item;
	endfunction

	initial begin
		item_t cell_item;
		int    count;
		int    idle_pct;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default 1024 x 1024 grid, unit ratios: corners and extreme coefficients
		send_cell(make_cell(0, 0, {8{32'h7FFF_FFFF}}), 0);
		send_cell(make_cell(1023, 1023, {8{32'h8000_0000}}), 0);
		send_cell(make_cell(1023, 0, {4{32'h7FFF_FFFF, 32'h8000_0000}}), 0);
		send_cell(make_cell(0, 1023, {4{32'h8000_0000, 32'h7FFF_FFFF}}), 0);
		send_cell(make_cell(512, 300, {8{32'hFFFF_FFFF}}), 0);
		send_cell(make_cell(5, 5, '0), 0);
		send_cell(make_cell(700, 2, random_faces()), 0);
		settle();

		// width 0 clamps to one column, height 2047 to the maximum; largest ratio
		write_config(11'd0, 11'd2047, 32'hFFFF_FFFF, 32'h0);
		send_cell(make_cell(0, 0, {8{32'h7FFF_FFFF}}), 0);
		send_cell(make_cell(0, 1023, {8{32'h8000_0000}}), 0);
		send_cell(make_cell(1, 0, random_faces()), 0);
		send_cell(make_cell(0, 512, random_faces()), 0);
		settle();

		// single cell grid, saturating sums
		write_config(11'd1, 11'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cell(make_cell(0, 0, {8{32'h7FFF_FFFF}}), 0);
		send_cell(make_cell(0, 0, {8{32'h8000_0000}}), 0);
		send_cell(make_cell(3, 7, random_faces()), 0);
		settle();

		write_config(11'd7, 11'd5, $urandom(), $urandom());
		send_cell(make_cell(6, 4, random_faces()), 0);
		send_cell(make_cell(0, 4, random_faces()), 0);
		send_cell(make_cell(6, 0, random_faces()), 0);
		send_cell(make_cell(7, 0, random_faces()), 0);
		send_cell(make_cell(3, 5, random_faces()), 0);
		send_cell(make_cell(3, 2, random_faces()), 0);
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: begin
				write_config(11'd2047, 11'd1024, $urandom(), $urandom());
				idle_pct = 0;
			end
			1: begin
				write_config(11'($urandom_range(16, 1)), 11'($urandom_range(16, 1)),
					32'($urandom_range(262144)), 32'($urandom_range(262144)));
				idle_pct = 85;
			end
			2: begin
				write_config(11'd0, 11'($urandom_range(8, 1)), 32'hFFFF_FFFF, 32'h0);
				idle_pct = 20;
			end
			3: begin
				write_config(11'($urandom_range(1024, 1)), 11'($urandom_range(1024, 1)),
					$urandom(), RATIO_RESET);
				idle_pct = 0;
			end
			default: begin
				write_config(11'($urandom_range(40, 2)), 11'd1,
					32'($urandom_range(131072)), 32'($urandom_range(131072)));
				idle_pct = 85;
			end
			endcase
			count = 0;
			while (count < CELLS_PER_PHASE) begin
				cell_item = random_cell();
				send_cell(cell_item, idle_pct);
				if (cell_item.cell_x < grid_w && cell_item.cell_y < grid_h) begin
					count++;
					if (count == CELLS_PER_PHASE / 2)
						settle();
				end
			end
			settle();
		end

		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/asca_pkg.sv
hw/rtl/asca_pipe.sv
hw/rtl/anisotropic_stencil_coo_assembly.sv
hw/rtl/asca_checker.sv
bench/stencil_entry_checker.sv
bench/tb_anisotropic_stencil_coo_assembly.sv
